// ===== rtl/assert_macros.svh =====
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent assertion on clk, switched off while rst is high
`define ASSERT_CLKRST(label, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("checker assertion failed");

// concurrent assertion on clk that also holds through reset
`define ASSERT_CLK(label, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("checker assertion failed");

`endif

// ===== rtl/sfrgt_pkg.sv =====
// shared constants, codes and field layout of the serial frame receiver
package sfrgt_pkg;

  localparam int unsigned BUF_DEPTH_DEFAULT = 256;

  // field widths
  localparam int unsigned CMD_W      = 2;
  localparam int unsigned DATA_W     = 8;
  localparam int unsigned STATUS_W   = 3;
  localparam int unsigned GAP_W      = 16;
  localparam int unsigned LEN_W      = 9;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 16;
  localparam int unsigned S_TDATA_W  = 16;
  localparam int unsigned M_TDATA_W  = 24;

  // output tdata layout
  localparam int unsigned OUT_STATUS_LSB = 0;
  localparam int unsigned OUT_COUNT_LSB  = 3;
  localparam int unsigned OUT_RDATA_LSB  = 11;
  localparam int unsigned OUT_ENABLE_BIT = 19;
  localparam int unsigned OUT_PAD_W      = M_TDATA_W - OUT_ENABLE_BIT - 1;

  // commands carried in s_tuser
  typedef enum logic [CMD_W-1:0] {
    CMD_ARM     = 2'd0,
    CMD_RX_BYTE = 2'd1,
    CMD_TICK    = 2'd2,
    CMD_READ    = 2'd3
  } cmd_t;

  // status codes
  localparam logic [STATUS_W-1:0] STATUS_IDLE       = 3'd0;
  localparam logic [STATUS_W-1:0] STATUS_MONITORING = 3'd1;
  localparam logic [STATUS_W-1:0] STATUS_STARTED    = 3'd2;
  localparam logic [STATUS_W-1:0] STATUS_COMPLETED  = 3'd3;
  localparam logic [STATUS_W-1:0] STATUS_TIMEOUT    = 3'd4;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_FRAME_GAP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_FIRST_WAIT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BUF_LEN    = 2'd2;

  // register reset values
  localparam logic [GAP_W-1:0] FRAME_GAP_RESET  = 16'd5;
  localparam logic [GAP_W-1:0] FIRST_WAIT_RESET = 16'd1000;
  localparam logic [LEN_W-1:0] BUF_LEN_RESET    = 9'd256;

endpackage

// ===== rtl/serial_frame_receiver_gap_timeout.sv =====
// serial frame receiver with idle gap end detection and first byte timeout
//
//  channel   | direction | handshake           | payload
//  ----------+-----------+---------------------+---------------------------------------
//  s_*       | in        | s_tvalid / s_tready | s_tuser command, s_tdata rx byte, index
//  m_*       | out       | m_tvalid / m_tready | m_tdata status, count, read data, enable
//  cfg_*     | in        | cfg_valid/cfg_ready | cfg_index, cfg_data
//
//  one transaction per cycle while the output is not stalled; each input transaction
//  gives one output transaction in the next cycle, from the registered output slot
//  reset: synchronous, clears control state and loads register defaults; the
//  frame store holds no reset value
//  a stalled output holds the single output slot and s_tready drops until it drains
//  cfg_ready is always high
module serial_frame_receiver_gap_timeout #(
  parameter int unsigned BUF_DEPTH = sfrgt_pkg::BUF_DEPTH_DEFAULT
) (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s_tvalid,
  output logic                                  s_tready,
  // [7:0] rx_data, [15:8] read_index
  input  logic [sfrgt_pkg::S_TDATA_W-1:0]       s_tdata,
  // [1:0] command
  input  logic [sfrgt_pkg::CMD_W-1:0]           s_tuser,
  output logic                                  m_tvalid,
  input  logic                                  m_tready,
  // [2:0] status, [10:3] byte_count, [18:11] read_data, [19] receive_enable, [23:20] zero
  output logic [sfrgt_pkg::M_TDATA_W-1:0]       m_tdata,
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  logic [sfrgt_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sfrgt_pkg::CFG_DATA_W-1:0]      cfg_data
);
  import sfrgt_pkg::*;

  localparam int unsigned AW = (BUF_DEPTH > 1) ? $clog2(BUF_DEPTH) : 1;
  localparam logic [LEN_W-1:0] DepthLen = LEN_W'(BUF_DEPTH);

  typedef enum logic [STATUS_W-1:0] {
    S_IDLE       = STATUS_IDLE,
    S_MONITORING = STATUS_MONITORING,
    S_STARTED    = STATUS_STARTED,
    S_COMPLETED  = STATUS_COMPLETED,
    S_TIMEOUT    = STATUS_TIMEOUT
  } state_t;

  // configuration registers
  logic [GAP_W-1:0] frame_gap_ticks;
  logic [GAP_W-1:0] first_byte_wait_ticks;
  logic [LEN_W-1:0] buffer_length;

  // receiver state
  state_t           rx_state, rx_state_next;
  logic [GAP_W-1:0] gap_counter, gap_counter_next;
  logic [GAP_W-1:0] wait_counter, wait_counter_next;
  logic [AW-1:0]    write_index, write_index_next;
  logic             rx_enabled, rx_enabled_next;

  // output slot
  logic              out_valid;
  logic              rd_sel;
  logic [DATA_W-1:0] rd_data;

  // frame store
  logic [DATA_W-1:0] frame_store [BUF_DEPTH];

  logic              accept;
  cmd_t              command;
  logic [DATA_W-1:0] rx_data;
  logic [DATA_W-1:0] read_index;
  logic [LEN_W-1:0]  len_eff;
  logic [LEN_W-1:0]  index_plus;
  logic              room;
  logic              wr_en;
  logic              rd_ok;
  logic              rd_en;

  assign s_tready   = !out_valid || m_tready;
  assign accept     = s_tvalid && s_tready;
  assign cfg_ready  = 1'b1;
  assign command    = cmd_t'(s_tuser);
  assign rx_data    = s_tdata[7:0];
  assign read_index = s_tdata[15:8];

  // length in use, capped at the store depth
  assign len_eff    = (buffer_length > DepthLen) ? DepthLen : buffer_length;
  assign index_plus = LEN_W'(write_index) + LEN_W'(1);
  assign room       = index_plus < len_eff;

  // reads past the store depth return zero
  assign rd_ok = {1'b0, read_index} < DepthLen;
  assign rd_en = accept && (command == CMD_READ) && rd_ok;

  // next state of the receiver for the current transaction
  always_comb begin
    rx_state_next     = rx_state;
    gap_counter_next  = gap_counter;
    wait_counter_next = wait_counter;
    write_index_next  = write_index;
    rx_enabled_next   = rx_enabled;
    wr_en             = 1'b0;
    unique case (command)
      CMD_ARM: begin
        // restart from any state; gap counter stays until the next byte
        write_index_next  = '0;
        wait_counter_next = first_byte_wait_ticks;
        rx_enabled_next   = 1'b1;
        rx_state_next     = S_MONITORING;
      end
      CMD_RX_BYTE: begin
        if (rx_state == S_MONITORING || rx_state == S_STARTED) begin
          gap_counter_next = frame_gap_ticks;
          rx_state_next    = S_STARTED;
          // store only while one slot of the length is still spare
          if (room) begin
            wr_en            = accept;
            write_index_next = write_index + AW'(1);
          end
        end
      end
      CMD_TICK: begin
        // a counter loaded with zero never expires
        if (rx_state == S_STARTED) begin
          if (gap_counter != '0) begin
            gap_counter_next = gap_counter - GAP_W'(1);
            if (gap_counter == GAP_W'(1)) begin
              rx_state_next   = S_COMPLETED;
              rx_enabled_next = 1'b0;
            end
          end
        end else if (rx_state == S_MONITORING) begin
          if (wait_counter != '0) begin
            wait_counter_next = wait_counter - GAP_W'(1);
            if (wait_counter == GAP_W'(1)) begin
              rx_state_next   = S_TIMEOUT;
              rx_enabled_next = 1'b0;
            end
          end
        end
      end
      CMD_READ: begin
      end
      default: begin
      end
    endcase
  end

  // control state, configuration and the output slot
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_gap_ticks       <= FRAME_GAP_RESET;
      first_byte_wait_ticks <= FIRST_WAIT_RESET;
      buffer_length         <= BUF_LEN_RESET;
      rx_state              <= S_IDLE;
      gap_counter           <= '0;
      wait_counter          <= '0;
      write_index           <= '0;
      rx_enabled            <= 1'b0;
      out_valid             <= 1'b0;
      rd_sel                <= 1'b0;
    end else begin
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_FRAME_GAP:  frame_gap_ticks       <= cfg_data;
          CFG_FIRST_WAIT: first_byte_wait_ticks <= cfg_data;
          CFG_BUF_LEN:    buffer_length         <= cfg_data[LEN_W-1:0];
          default: begin
          end
        endcase
      end
      if (accept) begin
        rx_state     <= rx_state_next;
        gap_counter  <= gap_counter_next;
        wait_counter <= wait_counter_next;
        write_index  <= write_index_next;
        rx_enabled   <= rx_enabled_next;
        out_valid    <= 1'b1;
        rd_sel       <= rd_en;
      end else if (m_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // frame store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      frame_store[write_index] <= rx_data;
    end
    if (rd_en) begin
      rd_data <= frame_store[read_index[AW-1:0]];
    end
  end

  // state only moves on accept, and accept waits for a free slot, so the
  // state registers show the result of the transaction held in the slot
  assign m_tvalid = out_valid;
  assign m_tdata  = {
    {OUT_PAD_W{1'b0}},
    rx_enabled,
    (rd_sel ? rd_data : {DATA_W{1'b0}}),
    DATA_W'(write_index),
    rx_state
  };

endmodule

// ===== rtl/sfrgt_checker.sv =====
// port level checker of the serial frame receiver and its bind
`include "assert_macros.svh"

module sfrgt_checker (
  input logic                                  clk,
  input logic                                  rst,
  input logic                                  s_tvalid,
  input logic                                  s_tready,
  input logic [sfrgt_pkg::CMD_W-1:0]           s_tuser,
  input logic                                  m_tvalid,
  input logic                                  m_tready,
  input logic [sfrgt_pkg::M_TDATA_W-1:0]       m_tdata
);
  import sfrgt_pkg::*;

  logic                in_xfer;
  logic                arm_xfer;
  logic                other_xfer;
  logic [STATUS_W-1:0] status;
  logic                enable;
  logic                receiving;
  logic [DATA_W-1:0]   rdata;

  assign in_xfer    = s_tvalid && s_tready;
  assign arm_xfer   = in_xfer && (s_tuser == CMD_ARM);
  assign other_xfer = in_xfer && (s_tuser != CMD_READ);
  assign status     = m_tdata[OUT_STATUS_LSB +: STATUS_W];
  assign enable     = m_tdata[OUT_ENABLE_BIT];
  assign receiving  = (status == STATUS_MONITORING) || (status == STATUS_STARTED);
  assign rdata      = m_tdata[OUT_RDATA_LSB +: DATA_W];

  // reset empties the output slot
  `ASSERT_CLK(a_reset_empties_slot, rst |=> !m_tvalid)

  // a stalled result is held
  `ASSERT_CLKRST(a_stall_holds, m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))

  // an arm transaction answers with monitoring and the receiver enabled
  `ASSERT_CLKRST(a_arm_monitors, arm_xfer |=> m_tvalid && status == STATUS_MONITORING && enable)

  // only a read transaction returns store data
  `ASSERT_CLKRST(a_read_data_zero, other_xfer |=> rdata == '0)

  // the receiver is enabled exactly while monitoring or started
  `ASSERT_CLKRST(a_enable_matches_status, m_tvalid |-> enable == receiving)

endmodule

bind serial_frame_receiver_gap_timeout sfrgt_checker u_sfrgt_checker (.*);

// ===== tb/sv/tb_top.sv =====
// testbench for the serial frame receiver: directed cases and random frame traffic
`timescale 1ns / 100ps

module tb_top;
  import sfrgt_pkg::*;

  localparam int unsigned DEPTH = BUF_DEPTH_DEFAULT;

  // one output transaction, laid out as m_tdata
  typedef struct packed {
    logic [3:0] pad;
    logic       enable;
    logic [7:0] rdata;
    logic [7:0] count;
    logic [2:0] status;
  } rx_result_t;

  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  s_tvalid  = 1'b0;
  logic                  s_tready;
  // [7:0] rx_data, [15:8] read_index
  logic [S_TDATA_W-1:0]  s_tdata   = '0;
  // [1:0] command
  logic [CMD_W-1:0]      s_tuser   = CMD_ARM;
  logic                  m_tvalid;
  logic                  m_tready  = 1'b0;
  // [2:0] status, [10:3] byte_count, [18:11] read_data, [19] receive_enable, [23:20] zero
  logic [M_TDATA_W-1:0]  m_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_FRAME_GAP;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  serial_frame_receiver_gap_timeout dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------------
  // receiver state as the testbench expects it
  // ---------------------------------------------------------------------------

  // register copies, changed only by write_register
  logic [GAP_W-1:0] gap_ticks  = FRAME_GAP_RESET;
  logic [GAP_W-1:0] wait_ticks = FIRST_WAIT_RESET;
  logic [LEN_W-1:0] buf_len    = BUF_LEN_RESET;

  logic [2:0]  exp_state  = STATUS_IDLE;
  logic [15:0] exp_gap    = '0;
  logic [15:0] exp_wait   = '0;
  logic [7:0]  exp_count  = '0;
  logic        exp_enable = 1'b0;
  logic [7:0]  frame_copy [DEPTH];
  bit          entry_written [DEPTH];
  int          n_written = 0;

  rx_result_t status_q [$];   // expected output transactions, oldest first

  // run statistics
  int n_items = 0, n_results = 0, n_mismatch = 0, n_issued = 0;
  int n_arms = 0, n_frames_done = 0, n_timeouts = 0, n_reads = 0;
  int n_cfg_writes = 0, n_settings = 0;

  // idle / stall percentages of the current phase
  int idle_pct  = 0;
  int stall_pct = 0;

  // applies one accepted command to the expected state and returns the result
  function automatic rx_result_t advance_receiver(cmd_t cmd, logic [7:0] data,
                                                  logic [7:0] ridx);
    rx_result_t  res;
    int unsigned len;
    res = '0;
    case (cmd)
      CMD_ARM: begin
        exp_count  = '0;
        exp_wait   = wait_ticks;
        exp_enable = 1'b1;
        exp_state  = STATUS_MONITORING;
        n_arms++;
      end
      CMD_RX_BYTE: begin
        // bytes count only while waiting for or inside a frame
        if (exp_state == STATUS_MONITORING || exp_state == STATUS_STARTED) begin
          len       = (buf_len > DEPTH) ? DEPTH : buf_len;
          exp_gap   = gap_ticks;
          exp_state = STATUS_STARTED;
          // last buffer slot is never filled, extra bytes are dropped
          if (int'(exp_count) + 1 < len) begin
            frame_copy[exp_count] = data;
            if (!entry_written[exp_count]) begin
              entry_written[exp_count] = 1'b1;
              n_written++;
            end
            exp_count++;
          end
        end
      end
      CMD_TICK: begin
        // a counter sitting at zero never expires
        if (exp_state == STATUS_STARTED) begin
          if (exp_gap != 0) begin
            exp_gap--;
            if (exp_gap == 0) begin
              exp_state  = STATUS_COMPLETED;
              exp_enable = 1'b0;
              n_frames_done++;
            end
          end
        end else if (exp_state == STATUS_MONITORING) begin
          if (exp_wait != 0) begin
            exp_wait--;
            if (exp_wait == 0) begin
              exp_state  = STATUS_TIMEOUT;
              exp_enable = 1'b0;
              n_timeouts++;
            end
          end
        end
      end
      CMD_READ: begin
        res.rdata = frame_copy[ridx];
        n_reads++;
      end
    endcase
    res.status = exp_state;
    res.count  = exp_count;
    res.enable = exp_enable;
    return res;
  endfunction

  // picks a store entry that has been written (caller makes sure one exists)
  function automatic logic [7:0] written_entry();
    logic [7:0] idx;
    do idx = 8'($urandom_range(DEPTH - 1)); while (!entry_written[idx]);
    return idx;
  endfunction

  // ---------------------------------------------------------------------------
  // monitor: predicts each accepted input transaction, checks each output one
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : result_check
    rx_result_t got, want;
    if (!rst) begin
      // prediction first, so the order within this block never matters
      if (s_tvalid && s_tready) begin
        status_q.push_back(advance_receiver(cmd_t'(s_tuser), s_tdata[7:0], s_tdata[15:8]));
        n_items++;
      end
      if (m_tvalid && m_tready) begin
        got = rx_result_t'(m_tdata);
        n_results++;
        if (status_q.size() == 0) begin
          n_mismatch++;
          if (n_mismatch <= 10)
            $display("%0t: output transaction %h with nothing expected", $time, m_tdata);
        end else begin
          want = status_q.pop_front();
          if (got.status !== want.status || got.count !== want.count ||
              got.rdata !== want.rdata || got.enable !== want.enable ||
              got.pad !== want.pad) begin
            n_mismatch++;
            if (n_mismatch <= 10) begin
              $display("%0t: mismatch (expected/actual) status %0d/%0d count %0d/%0d",
                       $time, want.status, got.status, want.count, got.count);
              $display("  read_data %h/%h enable %b/%b pad %h/%h",
                       want.rdata, got.rdata, want.enable, got.enable, want.pad, got.pad);
            end
          end
        end
      end
    end
  end

  // receiver backpressure, redrawn every cycle
  always @(negedge clk) m_tready <= ($urandom_range(99) >= stall_pct);

  // ---------------------------------------------------------------------------
  // stimulus tasks
  // ---------------------------------------------------------------------------

  // sends one command; arg is the byte or the read index, negative means random
  // (for a read: any entry already written, or a tick while nothing is)
  task automatic issue(cmd_t cmd, int arg);
    logic [7:0] data, ridx;
    cmd_t       c;
    @(negedge clk);
    while ($urandom_range(99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    // picked after the negedge so the monitor has seen every earlier write
    data = 8'($urandom);
    ridx = 8'($urandom);
    c    = cmd;
    if (cmd == CMD_RX_BYTE && arg >= 0) data = arg[7:0];
    if (cmd == CMD_READ) begin
      if (arg >= 0) ridx = arg[7:0];
      else if (n_written == 0) c = CMD_TICK;
      else ridx = written_entry();
    end
    s_tvalid <= 1'b1;
    s_tuser  <= c;
    s_tdata  <= {ridx, data};
    n_issued++;
    do @(posedge clk); while (!s_tready);
  endtask

  // stop sending and wait until every expected result has come out
  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (status_q.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      CFG_FRAME_GAP:  gap_ticks  = value;
      CFG_FIRST_WAIT: wait_ticks = value;
      CFG_BUF_LEN:    buf_len    = value[LEN_W-1:0];
      default: ;
    endcase
    n_cfg_writes++;
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // registers change only with the block idle
  task automatic configure(int gap, int first_wait, int len);
    wait_drained();
    write_register(CFG_FRAME_GAP, CFG_DATA_W'(gap));
    write_register(CFG_FIRST_WAIT, CFG_DATA_W'(first_wait));
    write_register(CFG_BUF_LEN, CFG_DATA_W'(len));
    n_settings++;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------

  // default registers: gap of five ticks, full buffer
  task automatic test_reset_defaults();
    issue(CMD_TICK, -1);          // tick while idle
    issue(CMD_RX_BYTE, 8'h3c);    // byte while idle is dropped
    issue(CMD_ARM, -1);
    issue(CMD_RX_BYTE, 8'h00);
    repeat (5) issue(CMD_TICK, -1);
    issue(CMD_RX_BYTE, 8'hff);    // frame already complete
    issue(CMD_READ, 0);
  endtask

  // first byte timeout, ignored traffic, drop of extra bytes, re-arm from each state
  task automatic test_timeout_and_ignored();
    configure(2, 3, 4);
    issue(CMD_ARM, -1);
    repeat (3) issue(CMD_TICK, -1);
    issue(CMD_RX_BYTE, 8'haa);
    issue(CMD_TICK, -1);
    issue(CMD_ARM, -1);
    issue(CMD_RX_BYTE, 8'hff);
    issue(CMD_RX_BYTE, 8'h5a);
    issue(CMD_TICK, -1);
    issue(CMD_RX_BYTE, 8'ha5);    // reloads the gap count
    issue(CMD_RX_BYTE, 8'h01);    // buffer full, dropped
    repeat (2) issue(CMD_TICK, -1);
    issue(CMD_RX_BYTE, 8'h77);
    issue(CMD_TICK, -1);
    issue(CMD_READ, 0);
    issue(CMD_READ, 1);
    issue(CMD_READ, 2);
    issue(CMD_ARM, -1);           // from completed
    issue(CMD_ARM, -1);           // from monitoring
    issue(CMD_RX_BYTE, 8'h80);
    issue(CMD_ARM, -1);           // from started, gap count left as it was
    issue(CMD_TICK, -1);
  endtask

  // zero counts never expire
  task automatic test_zero_counts();
    configure(0, 0, 2);
    issue(CMD_ARM, -1);
    repeat (3) issue(CMD_TICK, -1);
    issue(CMD_RX_BYTE, 8'h7e);
    repeat (3) issue(CMD_TICK, -1);
    issue(CMD_RX_BYTE, 8'h81);
    issue(CMD_READ, 0);
    configure(16'hffff, 16'hffff, 1);
    issue(CMD_ARM, -1);
    issue(CMD_RX_BYTE, 8'h11);    // one-entry buffer stores nothing
    issue(CMD_TICK, -1);
  endtask

  // zero length, lengths above the store depth, full frames and high indexes
  task automatic test_buffer_limits();
    logic [7:0] read_list [7] = '{8'd254, 8'd1, 8'd128, 8'd127, 8'd0, 8'd170, 8'd85};
    idle_pct  = 23;
    stall_pct = 23;
    configure(1, 2, 0);
    issue(CMD_ARM, -1);
    issue(CMD_RX_BYTE, 8'h22);
    issue(CMD_RX_BYTE, 8'h33);
    issue(CMD_TICK, -1);
    configure(3, 16'hffff, 511);  // capped at the depth
    issue(CMD_ARM, -1);
    repeat (DEPTH + 4) issue(CMD_RX_BYTE, -1);
    repeat (3) issue(CMD_TICK, -1);
    foreach (read_list[i])
      issue(CMD_READ, read_list[i]);
    configure(2, 5, DEPTH);
    issue(CMD_ARM, -1);
    repeat (8) issue(CMD_RX_BYTE, -1);
    repeat (2) issue(CMD_TICK, -1);
    issue(CMD_READ, 254);
    issue(CMD_READ, 1);
    idle_pct  = 0;
    stall_pct = 0;
  endtask

  // random register setting, extremes now and then
  task automatic random_setting();
    int r, gap, first_wait, len;
    r = $urandom_range(99);
    gap = (r < 10) ? 0 : (r < 15) ? 16'hffff : $urandom_range(1, 6);
    r = $urandom_range(99);
    first_wait = (r < 10) ? 0 : (r < 15) ? 16'hffff : $urandom_range(1, 10);
    r = $urandom_range(99);
    len = (r < 10) ? $urandom_range(0, 2) : (r < 20) ? $urandom_range(DEPTH, 511)
                                                     : $urandom_range(2, 20);
    configure(gap, first_wait, len);
  endtask

  // mostly well-formed frames with random content, the rest random commands;
  // a drained pause and a new setting halfway through
  task automatic test_random_traffic(int idle, int stall, int n);
    int start, gap, r;
    bit reconfigured;
    idle_pct     = idle;
    stall_pct    = stall;
    reconfigured = 1'b0;
    random_setting();
    start = n_issued;
    while (n_issued - start < n) begin
      if (!reconfigured && n_issued - start >= n / 2) begin
        random_setting();
        reconfigured = 1'b1;
      end
      gap = gap_ticks;
      r   = $urandom_range(99);
      if (r < 75) begin
        issue(CMD_ARM, -1);
        repeat ($urandom_range(0, 2)) issue(CMD_TICK, -1);
        repeat ($urandom_range(1, 10)) begin
          issue(CMD_RX_BYTE, -1);
          // silence shorter than the gap keeps the frame open
          if ($urandom_range(3) == 0 && gap > 1)
            repeat ($urandom_range(1, (gap - 1 > 4) ? 4 : gap - 1)) issue(CMD_TICK, -1);
        end
        repeat (((gap > 6) ? 6 : gap) + $urandom_range(0, 1)) issue(CMD_TICK, -1);
        repeat ($urandom_range(0, 2)) issue(CMD_READ, -1);
      end else begin
        issue(cmd_t'($urandom_range(3)), -1);
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (5) @(negedge clk);
    rst <= 1'b0;

    test_reset_defaults();
    test_timeout_and_ignored();
    test_zero_counts();
    test_buffer_limits();
    test_random_traffic(0, 0, 90);
    test_random_traffic(68, 0, 90);
    test_random_traffic(0, 68, 90);
    test_random_traffic(23, 23, 90);
    wait_drained();

    $display("covered %0d input transactions, %0d output transactions: %0d arms, %0d frames",
             n_items, n_results, n_arms, n_frames_done);
    $display("ended by silence, %0d first-byte timeouts, %0d reads, %0d settings (%0d writes)",
             n_timeouts, n_reads, n_settings, n_cfg_writes);
    if (n_mismatch == 0 && status_q.size() == 0) begin
      $display("** serial_frame_receiver_gap_timeout: PASSED **");
    end else begin
      $display("%0d mismatches, %0d results never seen", n_mismatch, status_q.size());
      $display("** serial_frame_receiver_gap_timeout: FAILED **");
    end
    $finish;
  end

  // watchdog, far beyond the slowest correct run
  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", status_q.size());
    $display("** serial_frame_receiver_gap_timeout: FAILED **");
    $finish;
  end

endmodule
